// ===== hw/rtl/rpn_pkg.sv =====
// Shared types and constants of the RPN stack calculator.
`default_nettype none
package rpn_pkg;
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_PRINT = 3'd1;
    localparam logic [2:0] EV_TRAP  = 3'd2;
    localparam logic [2:0] EV_UNDER = 3'd3;
    localparam logic [2:0] EV_OVER  = 3'd4;
    localparam logic [2:0] EV_DIVZ  = 3'd5;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_MOD  = 4'd5;
    localparam logic [3:0] OP_AND  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd8;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_PRT  = 4'd10;

    // Command from the front part to the back part.
    typedef struct packed {
        logic        push;   // push number first
        logic [31:0] number;
        logic [3:0]  op;
    } t_cmd;

    function automatic logic [3:0] decode_op(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            8'h2B: r = OP_ADD;
            8'h2D: r = OP_SUB;
            8'h2A: r = OP_MUL;
            8'h2F: r = OP_DIV;
            8'h25: r = OP_MOD;
            8'h26: r = OP_AND;
            8'h7C: r = OP_OR;
            8'h5E: r = OP_XOR;
            8'h7E: r = OP_NOT;
            8'h70: r = OP_PRT;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rpn_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_front.sv =====
// Front part: number building, operator classification and a two-entry request queue.
`default_nettype none
module rpn_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_char,
    output logic             o_ready,
    output logic             o_cmd_valid,
    output rpn_pkg::t_cmd    o_cmd,
    output logic             o_skip,      // digit: item yields a none event directly
    input  wire              i_cmd_ready
);
    import rpn_pkg::*;
    logic [31:0] r_acc;
    logic        r_in_num;
    logic        w_digit;
    logic [31:0] w_next;
    t_cmd        w_cmd;
    logic        w_push, w_pop;
    // two-entry queue toward the back part
    t_cmd        r_qcmd [2];
    logic [1:0]  r_qskip;
    logic        r_wp, r_rp;
    logic [1:0]  r_fill;

    assign w_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign w_next = (r_in_num ? (r_acc << 3) + (r_acc << 1) : 32'd0)
                  + {28'd0, i_char[3:0]};
    assign w_cmd.push = r_in_num && !w_digit;
    assign w_cmd.number = r_acc;
    assign w_cmd.op = w_digit ? OP_NONE : decode_op(i_char);

    assign o_ready = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd = r_qcmd[r_rp];
    assign o_skip = r_qskip[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_num <= 1'b0;
            r_acc    <= 32'd0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_in_num <= w_digit;
                if (w_digit) begin
                    r_acc <= w_next;
                end
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qcmd[r_wp]  <= w_cmd;
            r_qskip[r_wp] <= w_digit;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_div.sv =====
// Iterative signed divider, one quotient bit per cycle.
`default_nettype none
module rpn_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, r_d;
    logic [32:0] r_r;
    logic [5:0]  r_cnt;
    logic        r_busy, r_nq, r_nr;
    logic [32:0] w_sh, w_sub;

    assign w_sh  = {r_r[31:0], r_q[31]};
    assign w_sub = w_sh - {1'b0, r_d};
    assign o_quot = r_nq ? -r_q : r_q;
    assign o_rem  = r_nr ? -r_r[31:0] : r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_num[31] ? -i_num : i_num;
                r_d    <= i_den[31] ? -i_den : i_den;
                r_r    <= 33'd0;
                r_nq   <= i_num[31] ^ i_den[31];
                r_nr   <= i_num[31];
            end else if (r_busy) begin
                if (!w_sub[32]) begin
                    r_r <= w_sub;
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= w_sh;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_back.sv =====
// Back part: stack sequencer, ALU and result register.
`default_nettype none
module rpn_back #(
    parameter int STACK_DEPTH = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  rpn_pkg::t_cmd    i_cmd,
    input  wire              i_skip,
    output logic             o_ready,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_value,
    input  wire              i_ready
);
    import rpn_pkg::*;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_st;
    logic [CW-1:0] r_cnt;
    logic [3:0]    r_op;
    logic [31:0]   r_a, r_b, r_mul;
    logic [1:0]    r_wait;
    logic          r_we;
    logic [AW-1:0] r_addr;
    logic [31:0]   r_wdata;
    logic [31:0]   w_rdata;
    logic          r_dstart;
    logic          w_ddone;
    logic [31:0]   w_quot, w_rem;

    rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_addr),
        .i_wdata(r_wdata), .o_rdata(w_rdata));

    rpn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_a), .i_den(r_b), .o_done(w_ddone), .o_quot(w_quot), .o_rem(w_rem));

    assign o_ready = (r_st == S_IDLE) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
            r_we     <= 1'b0;
            r_dstart <= 1'b0;
            r_wait   <= 2'd0;
        end else begin
            r_we     <= 1'b0;
            r_dstart <= 1'b0;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        o_kind  <= EV_NONE;
                        o_value <= 32'd0;
                        r_op    <= i_cmd.op;
                        if (i_skip || (!i_cmd.push && i_cmd.op == OP_NONE)) begin
                            o_valid <= 1'b1;
                        end else if (i_cmd.push && r_cnt == FULL) begin
                            o_kind  <= EV_OVER;
                            o_valid <= 1'b1;
                        end else begin
                            if (i_cmd.push) begin
                                r_we    <= 1'b1;
                                r_addr  <= r_cnt[AW-1:0];
                                r_wdata <= i_cmd.number;
                                r_cnt   <= r_cnt + 1'b1;
                            end
                            if (i_cmd.op == OP_NONE) begin
                                o_valid <= 1'b1;
                            end else begin
                                r_st <= S_RD1;
                            end
                        end
                    end
                end
                S_RD1: begin
                    if (r_cnt == '0) begin
                        o_kind  <= EV_UNDER;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else begin
                        r_addr <= AW'(r_cnt - 1'b1);
                        r_wait <= 2'd2;
                        r_st   <= S_RD2;
                    end
                end
                S_RD2: begin
                    if (r_wait != 2'd0) begin
                        r_wait <= r_wait - 2'd1;
                        if (r_wait == 2'd1) begin
                            r_b <= w_rdata;
                            if (r_op == OP_NOT || r_op == OP_PRT || r_cnt == CW'(1)) begin
                                r_st <= S_EXE;
                            end else begin
                                r_addr <= AW'(r_cnt - CW'(2));
                                r_wait <= 2'd0;
                                r_st   <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV: begin
                    // wait here for the second read to come out of the RAM
                    r_st <= S_DONE;
                end
                S_DONE: begin
                    r_a   <= w_rdata;
                    r_mul <= w_rdata * r_b;
                    r_st  <= S_EXE;
                    r_wait <= 2'd3;
                    if ((r_op == OP_DIV || r_op == OP_MOD) && r_b != 32'd0) begin
                        r_dstart <= 1'b1;
                    end
                end
                S_EXE: begin
                    if (r_op == OP_PRT) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_b == 32'hFFFF_FFFF) begin
                            o_kind <= EV_TRAP;
                        end else begin
                            o_kind  <= EV_PRINT;
                            o_value <= r_b;
                        end
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else if (r_op == OP_NOT) begin
                        r_we    <= 1'b1;
                        r_wdata <= ~r_b;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else if (r_wait != 2'd3) begin
                        // binary op with a single operand: stack unchanged
                        o_kind  <= EV_UNDER;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_b != 32'd0
                                 && !w_ddone) begin
                        r_st <= S_EXE;
                    end else begin
                        r_we   <= 1'b1;
                        r_addr <= AW'(r_cnt - CW'(2));
                        r_cnt  <= r_cnt - 1'b1;
                        case (r_op)
                            OP_ADD: r_wdata <= r_a + r_b;
                            OP_SUB: r_wdata <= r_a - r_b;
                            OP_MUL: r_wdata <= r_mul;
                            OP_AND: r_wdata <= r_a & r_b;
                            OP_OR:  r_wdata <= r_a | r_b;
                            OP_XOR: r_wdata <= r_a ^ r_b;
                            OP_DIV: r_wdata <= (r_b == 32'd0) ? 32'd0 : w_quot;
                            default: r_wdata <= (r_b == 32'd0) ? 32'd0 : w_rem;
                        endcase
                        if (r_b == 32'd0 && (r_op == OP_DIV || r_op == OP_MOD)) begin
                            o_kind <= EV_DIVZ;
                        end
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_stack_calculator.sv =====
// Top level: RPN calculator, one character per request, one result per request.
// Digits and separators need no stack read; p and ~ read one word; + - * & | ^ read two;
// / and % read two and then run the 32-step shift-subtract divider unless the divisor is 0.
// Throughput: one request at a time in the back part; a two-entry queue buffers requests.
// Reset (synchronous, active low) empties the stack, the queue and the pending number;
// stack words stay undefined until pushed.
`default_nettype none
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);
    import rpn_pkg::*;
    t_cmd        w_cmd;
    logic        w_cvalid, w_cready, w_skip;

    rpn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_char(s_axis_tdata), .o_ready(s_axis_tready), .o_cmd_valid(w_cvalid),
        .o_cmd(w_cmd), .o_skip(w_skip), .i_cmd_ready(w_cready));

    rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_cvalid), .i_cmd(w_cmd),
        .i_skip(w_skip), .o_ready(w_cready), .o_valid(m_axis_tvalid),
        .o_kind(m_axis_tuser), .o_value(m_axis_tdata), .i_ready(m_axis_tready));
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_checker.sv =====
// Port-level checker for the RPN calculator, bound to the top level.
`default_nettype none
module rpn_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);
    import rpn_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= EV_DIVZ)
        else $error("bad event kind");
    a_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != EV_PRINT |-> m_axis_tdata == 32'd0)
        else $error("value not zero");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");
endmodule

bind rpn_stack_calculator rpn_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser));
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the RPN stack calculator: random character streams, scoreboard.
`timescale 1ns / 1ps
module testbench;
    import rpn_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    logic [7:0]  pending_chars[$];
    t_event      expected_events[$];
    int          error_count = 0;
    bit          in_taken = 1'b0;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    int          hold_cycles = 0;
    int          hold_request = 0;

    // model state
    logic [31:0] calc_stack[DEPTH];
    int          calc_count = 0;
    logic [31:0] calc_acc = '0;
    bit          calc_in_num = 1'b0;

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // [7:0] char_code
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // [31:0] value
        .m_axis_tuser(m_axis_tuser)    // [2:0] event_kind
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit calc_push(logic [31:0] v);
        if (calc_count >= DEPTH) return 1'b0;
        calc_stack[calc_count] = v;
        calc_count++;
        return 1'b1;
    endfunction

    function automatic logic [31:0] apply_binary(logic [3:0] op, logic [31:0] l,
                                                 logic [31:0] r, inout logic [2:0] kind);
        logic signed [31:0] sl, sr;
        sl = l;
        sr = r;
        case (op)
            OP_ADD: return l + r;
            OP_SUB: return l - r;
            OP_MUL: return l * r;
            OP_AND: return l & r;
            OP_OR:  return l | r;
            OP_XOR: return l ^ r;
            default: ;
        endcase
        if (r == 0) begin
            kind = EV_DIVZ;
            return '0;
        end
        // most negative by minus one wraps
        if (sl == 32'sh80000000 && sr == -1) return (op == OP_DIV) ? l : '0;
        return (op == OP_DIV) ? sl / sr : sl % sr;
    endfunction

    function automatic t_event calc_step(logic [7:0] c);
        t_event      ev;
        logic [3:0]  op;
        logic [31:0] a, b;
        bit          was_num;
        ev = '{kind: EV_NONE, value: '0};
        op = OP_NONE;
        case (c)
            "+": op = OP_ADD;
            "-": op = OP_SUB;
            "*": op = OP_MUL;
            "/": op = OP_DIV;
            "%": op = OP_MOD;
            "&": op = OP_AND;
            "|": op = OP_OR;
            "^": op = OP_XOR;
            "~": op = OP_NOT;
            "p": op = OP_PRT;
            default: ;
        endcase
        if (c >= "0" && c <= "9") begin
            if (!calc_in_num) calc_acc = '0;
            calc_acc = calc_acc * 10 + (c - "0");
            calc_in_num = 1'b1;
            return ev;
        end
        was_num = calc_in_num;
        calc_in_num = 1'b0;
        if (was_num && !calc_push(calc_acc)) begin
            ev.kind = EV_OVER;
        end else if (op == OP_PRT || op == OP_NOT) begin
            if (calc_count == 0) begin
                ev.kind = EV_UNDER;
            end else begin
                calc_count--;
                a = calc_stack[calc_count];
                if (op == OP_NOT) begin
                    void'(calc_push(~a));
                end else if (a == 32'hFFFF_FFFF) begin
                    ev.kind = EV_TRAP;
                end else begin
                    ev.kind = EV_PRINT;
                    ev.value = a;
                end
            end
        end else if (op != OP_NONE) begin
            if (calc_count < 2) begin
                ev.kind = EV_UNDER;
            end else begin
                b = calc_stack[calc_count - 1];
                a = calc_stack[calc_count - 2];
                calc_count -= 2;
                calc_stack[calc_count] = apply_binary(op, a, b, ev.kind);
                calc_count++;
            end
        end
        return ev;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    endtask

    task automatic add_number(logic [31:0] v);
        add_text($sformatf("%0d ", v));
    endtask

    // driver: hold the request until it is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                in_taken = 1'b0;
                if (pending_chars.size() > 0 && (quiet_sender || $urandom_range(99) >= 15)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_chars[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_request > 0) begin
                hold_cycles = hold_request;
                hold_request = 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet_receiver || $urandom_range(99) >= 15;
            end
        end
    end

    // monitor: predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_event got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_events.push_back(calc_step(s_axis_tdata));
                void'(pending_chars.pop_front());
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.value = m_axis_tdata;
                if (expected_events.size() == 0) begin
                    $error("unexpected result kind %0d value %0h", got.kind, got.value);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("event_kind expected %0d actual %0d", want.kind, got.kind);
                        error_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("value expected %0h actual %0h", want.value, got.value);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        string ops;
        int    n;
        ops = "+-*/%&|^~p";
        // directed
        add_text("p~+ 5+ ");
        add_number(32'h7FFF_FFFF); add_text("1+p");
        add_text("4294967295p 4294967296p 99999999999p");
        add_text("2147483648 1-/p 2147483648 1-%p");
        add_text("7 0/p 7 0%p 7 2-/p 7 2-%p 0 7-3%p");
        add_text("6 3*p 12 10&p 12 10|p 12 10^p 5~p 0~p");
        add_text("\000\377 ");
        for (int i = 0; i < DEPTH + 2; i++) add_text("1 ");
        add_text("+5+");
        for (int i = 0; i < DEPTH + 3; i++) add_text("p");
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // random: mostly well-formed expressions, some noise
        n = pending_chars.size();
        while (pending_chars.size() + n < 1850 + n) begin
            if (n > 1850) break;
            case ($urandom_range(9))
                0: add_number($urandom());
                1, 2, 3: add_number($urandom_range(20));
                4: add_text($sformatf("%0d", $urandom_range(1000)));
                5, 6, 7: add_text({string'(ops[$urandom_range(7)]), " "});
                8: add_text({string'(ops[8 + $urandom_range(1)])});
                default: pending_chars.push_back(8'($urandom_range(255)));
            endcase
            n += 3;
            // long quiet stretch in the middle
            if (n > 900 && n < 1100) begin
                quiet_sender = 1'b1;
                quiet_receiver = 1'b1;
            end else begin
                quiet_sender = 1'b0;
                quiet_receiver = 1'b0;
            end
            if (n > 600 && n < 604) hold_request = 3000;
            wait (pending_chars.size() < 8);
        end
        add_text("p");
        wait (pending_chars.size() == 0 && !s_axis_tvalid);
        wait (expected_events.size() == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_front.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_back.sv
hw/rtl/rpn_stack_calculator.sv
hw/rtl/rpn_checker.sv
dv/testbench.sv
